### src/utq_pkg.sv
`default_nettype none
package utq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int TICKET_W    = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READOUT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_UPDATE,
        OP_READ_FIRST,
        OP_READ_NEXT
    } op_t;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic             empty;
        logic             last_first;
        logic             last_next;
        logic             out_free;
    } dp_status_t;

endpackage
`default_nettype wire

### src/utq_ctrl.sv
`default_nettype none
module utq_ctrl
    import utq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output op_t             op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (status.kind) inside
                    REQ_INSERT, REQ_REMOVE: begin
                        if (status.out_free) begin
                            state_next = S_IDLE;
                        end
                    end
                    REQ_READOUT: begin
                        if (status.out_free) begin
                            if (status.empty || status.last_first) begin
                                state_next = S_IDLE;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                if (status.out_free && status.last_next) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        op       = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op = OP_CAPTURE;
                end
            end
            S_EXEC: begin
                unique case (status.kind) inside
                    REQ_INSERT, REQ_REMOVE: begin
                        if (status.out_free) begin
                            op = OP_UPDATE;
                        end
                    end
                    REQ_READOUT: begin
                        if (status.out_free) begin
                            op = OP_READ_FIRST;
                        end
                    end
                    default: begin
                        op = OP_NONE;
                    end
                endcase
            end
            S_READ: begin
                if (status.out_free) begin
                    op = OP_READ_NEXT;
                end
            end
            default: begin
                op = OP_NONE;
            end
        endcase
    end

endmodule
`default_nettype wire

### src/utq_datapath.sv
`default_nettype none
module utq_datapath
    import utq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire op_t                 op,
    input  wire logic [REQ_W-1:0]    in_kind,
    input  wire logic [TICKET_W-1:0] in_ticket,
    input  wire logic                out_ready,
    output dp_status_t               status,
    output logic                     out_valid,
    output logic [STATUS_W-1:0]      out_status,
    output logic [TICKET_W-1:0]      out_value,
    output logic                     out_last
);

    logic [REQ_W-1:0]    kind_reg;
    logic [TICKET_W-1:0] ticket_reg;
    logic [TICKET_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [TICKET_W-1:0] entry_next [QUEUE_DEPTH];
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    rd_idx_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [TICKET_W-1:0] out_value_reg;
    logic [TICKET_W-1:0] out_value_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] first_hit;
    logic [QUEUE_DEPTH-1:0] shift_mask;
    logic                   found;
    logic                   full;
    logic                   empty;
    logic                   out_free;
    logic                   last_first;
    logic                   last_next;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            match[i] = (OCC_W'(i) < occ_reg) && (entry_reg[i] == ticket_reg);
        end
    end

    assign found      = |match;
    assign first_hit  = match & (~match + QUEUE_DEPTH'(1));
    assign shift_mask = ~(first_hit - QUEUE_DEPTH'(1));
    assign full       = (occ_reg == OCC_W'(QUEUE_DEPTH));
    assign empty      = (occ_reg == '0);
    assign out_free   = !out_valid_reg || out_ready;
    assign last_first = (occ_reg == OCC_W'(1));
    assign last_next  = ((OCC_W'(rd_idx_reg) + OCC_W'(1)) == occ_reg);

    always_comb begin
        entry_next      = entry_reg;
        occ_next        = occ_reg;
        rd_idx_next     = rd_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        unique case (op)
            OP_UPDATE: begin
                out_valid_next = 1'b1;
                out_value_next = '0;
                out_last_next  = 1'b1;
                if (kind_reg == REQ_INSERT) begin
                    if (found) begin
                        out_status_next = ST_DUP;
                    end else if (full) begin
                        out_status_next = ST_FULL;
                    end else begin
                        out_status_next = ST_OK;
                        entry_next[occ_reg[IDX_W-1:0]] = ticket_reg;
                        occ_next = occ_reg + OCC_W'(1);
                    end
                end else begin
                    if (!found) begin
                        out_status_next = ST_MISSING;
                    end else begin
                        out_status_next = ST_OK;
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            if (shift_mask[i]) begin
                                entry_next[i] = entry_reg[i + 1];
                            end
                        end
                        occ_next = occ_reg - OCC_W'(1);
                    end
                end
            end
            OP_READ_FIRST: begin
                out_valid_next = 1'b1;
                if (empty) begin
                    out_status_next = ST_EMPTY;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                end else begin
                    out_status_next = ST_OK;
                    out_value_next  = entry_reg[0];
                    out_last_next   = last_first;
                end
                rd_idx_next = IDX_W'(1);
            end
            OP_READ_NEXT: begin
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_value_next  = entry_reg[rd_idx_reg];
                out_last_next   = last_next;
                rd_idx_next     = rd_idx_reg + IDX_W'(1);
            end
            default: begin
                rd_idx_next = rd_idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_CAPTURE) begin
            kind_reg   <= in_kind;
            ticket_reg <= in_ticket;
        end
        entry_reg      <= entry_next;
        rd_idx_reg     <= rd_idx_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign status.kind       = kind_reg;
    assign status.empty      = empty;
    assign status.last_first = last_first;
    assign status.last_next  = last_next;
    assign status.out_free   = out_free;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_UPDATE || op == OP_READ_FIRST || op == OP_READ_NEXT) |-> out_free)
        else $error("pending result overwritten");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_UPDATE || op == OP_READ_FIRST || op == OP_READ_NEXT) |=> out_valid_reg)
        else $error("loaded result not presented");

    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (occ_reg == $past(occ_reg) || occ_reg == $past(occ_reg) + OCC_W'(1)
                  || occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("occupancy moved by more than one");

endmodule
`default_nettype wire

### src/unique_ticket_queue.sv
// Ordered queue of distinct 32-bit tickets with insert, remove-by-value and readout.
// Input channel s_*: s_tuser carries the request kind (insert, remove, readout),
// s_tdata the ticket. Kind 3 is dropped with no result.
// Result channel m_*: m_tuser carries the status, m_tdata the entry value
// (zero outside a readout), m_tlast marks the final result of a request.
// Insert and remove give one result each; readout gives one result per queued
// entry, head first, or a single empty-status result.
// Timing: a request is captured into registers, then executed in S_EXEC once the
// output register is free, where all entries are compared in parallel and a remove
// closes the gap in the same cycle. Insert and remove give their result from S_EXEC.
// Readout: S_EXEC sends the head entry and S_READ the rest, one entry per cycle
// through the output register while m_tready keeps it free.
// While a result waits in the output register, the next request is still taken;
// execution holds until m_tready frees the register, so a stalled receiver
// stalls the block with nothing lost.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none
module unique_ticket_queue
    import utq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] ticket
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] entry_value
    output logic [2:0]       m_tuser,   // [2:0] status
    output logic             m_tlast
);

    op_t        op;
    dp_status_t status;

    utq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    utq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .in_kind    (s_tuser),
        .in_ticket  (s_tdata),
        .out_ready  (m_tready),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_value  (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import utq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_PCT      = 31;
    localparam int MAX_SHOWN     = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TARGET_REQS   = 130;
    localparam int POOL_SIZE     = 48;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic [REQ_W-1:0]    kind;
        logic [TICKET_W-1:0] ticket;
        bit                  pause;
        bit                  calm;
    } ticket_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TICKET_W-1:0] entry;
        logic                last;
    } queue_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    ticket_req_t         request_backlog[$];
    queue_result_t       due_results[$];
    logic [TICKET_W-1:0] shadow_tickets[$];
    logic [TICKET_W-1:0] ticket_pool[$];
    int                  mismatches   = 0;
    int                  cycle_count  = 0;
    int                  counted_reqs = 0;
    bit                  req_fire     = 1'b0;
    bit                  calm_mode    = 1'b0;
    bit                  gen_calm     = 1'b0;

    unique_ticket_queue DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void report_error(string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void push_result(logic [STATUS_W-1:0] status,
                                        logic [TICKET_W-1:0] entry, logic last);
        queue_result_t r;
        r.status = status;
        r.entry  = entry;
        r.last   = last;
        due_results.push_back(r);
    endfunction

    function automatic int find_ticket(logic [TICKET_W-1:0] t);
        for (int k = 0; k < shadow_tickets.size(); k++) begin
            if (shadow_tickets[k] == t) begin
                return k;
            end
        end
        return -1;
    endfunction

    function automatic void apply_request(logic [REQ_W-1:0] kind, logic [TICKET_W-1:0] t);
        int pos;
        pos = find_ticket(t);
        case (kind)
            REQ_INSERT: begin
                if (pos >= 0) begin
                    push_result(ST_DUP, '0, 1'b1);
                end else if (shadow_tickets.size() >= QUEUE_DEPTH) begin
                    push_result(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_tickets.push_back(t);
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            REQ_REMOVE: begin
                if (pos < 0) begin
                    push_result(ST_MISSING, '0, 1'b1);
                end else begin
                    shadow_tickets.delete(pos);
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            REQ_READOUT: begin
                if (shadow_tickets.size() == 0) begin
                    push_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    foreach (shadow_tickets[k]) begin
                        push_result(ST_OK, shadow_tickets[k], k == shadow_tickets.size() - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic add_request(logic [REQ_W-1:0] kind, logic [TICKET_W-1:0] t);
        ticket_req_t r;
        r.kind   = kind;
        r.ticket = t;
        r.pause  = 1'b0;
        r.calm   = gen_calm;
        request_backlog.push_back(r);
        if (kind != REQ_UNUSED) begin
            counted_reqs++;
        end
        if (kind == REQ_INSERT) begin
            ticket_pool.push_back(t);
            if (ticket_pool.size() > POOL_SIZE) begin
                ticket_pool.delete(0);
            end
        end
    endtask

    task automatic add_pause();
        ticket_req_t r;
        r.kind   = REQ_INSERT;
        r.ticket = '0;
        r.pause  = 1'b1;
        r.calm   = gen_calm;
        request_backlog.push_back(r);
    endtask

    function automatic logic [TICKET_W-1:0] pick_ticket();
        if (ticket_pool.size() == 0) begin
            return $urandom;
        end
        return ticket_pool[$urandom_range(ticket_pool.size() - 1)];
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !req_fire) begin
            // hold the request until accepted
        end else if (request_backlog.size() != 0 && request_backlog[0].pause) begin
            s_tvalid <= 1'b0;
            if (due_results.size() == 0) begin
                request_backlog.delete(0);
            end
        end else if (request_backlog.size() == 0 ||
                     (!calm_mode && $urandom_range(99) < IDLE_PCT)) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid  <= 1'b1;
            s_tuser   <= request_backlog[0].kind;
            s_tdata   <= request_backlog[0].ticket;
            calm_mode <= request_backlog[0].calm;
            request_backlog.delete(0);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm_mode || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin : result_check
        queue_result_t want;
        if (!aresetn) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_error($sformatf("unexpected result status=%0d entry=%h last=%b",
                                           m_tuser, m_tdata, m_tlast));
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.status || m_tdata !== want.entry ||
                        m_tlast !== want.last) begin
                        report_error($sformatf(
                            "expected status=%0d entry=%h last=%b, got status=%0d entry=%h last=%b",
                            want.status, want.entry, want.last, m_tuser, m_tdata, m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int episode;
        int roll;

        add_request(REQ_READOUT, 32'h0000_0000);
        add_request(REQ_REMOVE,  32'h0000_0000);
        add_request(REQ_INSERT,  32'h8000_0000);
        add_request(REQ_INSERT,  32'h7FFF_FFFF);
        add_request(REQ_INSERT,  32'h0000_0000);
        add_request(REQ_INSERT,  32'hFFFF_FFFF);
        add_request(REQ_INSERT,  32'h7FFF_FFFF);
        add_request(REQ_READOUT, 32'hFFFF_FFFF);
        add_request(REQ_REMOVE,  32'h0000_0000);
        add_request(REQ_REMOVE,  32'h0000_0001);
        add_request(REQ_UNUSED,  32'h7FFF_FFFF);
        add_request(REQ_READOUT, 32'h5555_AAAA);
        add_request(REQ_REMOVE,  32'hFFFF_FFFF);
        add_request(REQ_REMOVE,  32'h8000_0000);
        add_request(REQ_INSERT,  32'h8000_0000);
        add_request(REQ_READOUT, 32'h0000_0000);
        add_request(REQ_REMOVE,  32'h7FFF_FFFF);
        add_request(REQ_REMOVE,  32'h8000_0000);
        add_request(REQ_READOUT, 32'h0000_0000);
        add_pause();

        episode = 0;
        while (counted_reqs < TARGET_REQS) begin
            gen_calm = (episode == 3);
            if (episode == 0) begin
                // fill from empty, overflow, then a duplicate while full
                for (int k = 0; k <= QUEUE_DEPTH; k++) begin
                    add_request(REQ_INSERT, $urandom);
                end
                add_request(REQ_INSERT, ticket_pool[ticket_pool.size() - 2]);
                add_request(REQ_READOUT, $urandom);
                for (int k = 0; k < 4; k++) begin
                    add_request(REQ_REMOVE, pick_ticket());
                end
                add_request(REQ_READOUT, $urandom);
            end else begin
                if (episode == 4) begin
                    add_pause();
                end
                repeat (episode == 3 ? 20 : 10) begin
                    roll = $urandom_range(99);
                    if (roll < 35) begin
                        add_request(REQ_INSERT, $urandom_range(1) ? pick_ticket() : $urandom);
                    end else if (roll < 70) begin
                        add_request(REQ_REMOVE,
                                    ($urandom_range(3) != 0) ? pick_ticket() : $urandom);
                    end else if (roll < 92) begin
                        add_request(REQ_READOUT, $urandom);
                    end else begin
                        add_request(REQ_UNUSED, $urandom);
                    end
                end
            end
            episode++;
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (request_backlog.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
